@@ rtl/abp_pkg.sv @@
// Shared types, constants and helpers for the Annex B byte stream packer.
package abp_pkg;

   // codec selection codes
   localparam logic [1:0] CODEC_H264  = 2'd0;
   localparam logic [1:0] CODEC_HEVC  = 2'd1;
   localparam logic [1:0] CODEC_VVC   = 2'd2;
   localparam logic [1:0] CODEC_OTHER = 2'd3;

   // fixed stream bytes
   localparam logic [7:0] BYTE_ZERO   = 8'h00;
   localparam logic [7:0] BYTE_SC_END = 8'h01;
   localparam logic [7:0] BYTE_EPB    = 8'h03;

   // slot positions of one item's output, in emission order
   localparam int POS_ZB   = 0;
   localparam int POS_SC0  = 1;
   localparam int POS_SC1  = 2;
   localparam int POS_SC2  = 3;
   localparam int POS_EPB  = 4;
   localparam int POS_DATA = 5;
   localparam int NUM_POS  = 6;

   // decoupling queue depth
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // classified item handed from the front to the back
   typedef struct packed {
      logic       need_zb;
      logic       start;
      logic       esc;
      logic       has_pl;
      logic [7:0] data;
   } abp_desc_type;

   typedef logic [NUM_POS-1:0] abp_mask_type;

   // leading zero rule
   function automatic logic lead_zero_needed(input logic [1:0] kind,
                                             input logic [5:0] utype,
                                             input logic       first);
      logic r;
      r = 1'b0;
      case (kind)
         CODEC_H264: r = (utype inside {6'd7, 6'd8});
         CODEC_HEVC: r = (utype inside {[6'd32:6'd34]});
         CODEC_VVC:  r = (utype inside {[6'd12:6'd18]});
         default:    r = 1'b0;
      endcase
      return first | r;
   endfunction

endpackage

@@ rtl/abp_req_if.sv @@
// Input channel: NAL unit payload transactions.
interface abp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       has_payload;
   logic       unit_start;
   logic       first_unit;
   logic [5:0] unit_type;

   modport source (output valid, payload_byte, has_payload, unit_start, first_unit,
                   unit_type, input ready);
   modport sink   (input valid, payload_byte, has_payload, unit_start, first_unit,
                   unit_type, output ready);
endinterface

@@ rtl/abp_rsp_if.sv @@
// Output channel: Annex B stream byte transactions.
interface abp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, out_byte, last_of_run, input ready);
   modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

@@ rtl/abp_front.sv @@
// Front end: accepts input transactions, tracks the zero run, classifies each item.
module abp_front
   import abp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   codec_kind,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [7:0]   payload_byte,
   input  logic         has_payload,
   input  logic         unit_start,
   input  logic         first_unit,
   input  logic [5:0]   unit_type,
   input  logic         queue_full,
   output logic         push,
   output abp_desc_type push_desc
);

   logic [1:0] zero_count_ff;
   logic [1:0] zero_count_in;
   logic [1:0] zc_base;
   logic       is_zero;
   logic       esc;
   logic       accept;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign is_zero  = (payload_byte == BYTE_ZERO);
   // a unit start clears the run before its payload byte is looked at
   assign zc_base  = unit_start ? 2'd0 : zero_count_ff;

   // zero run update and escape decision
   always_comb begin
      esc           = 1'b0;
      zero_count_in = zc_base;
      if (has_payload) begin
         if (zc_base < 2'd2) begin
            zero_count_in = is_zero ? zc_base + 2'd1 : 2'd0;
         end else begin
            esc           = (payload_byte[7:2] == 6'd0);
            zero_count_in = is_zero ? 2'd1 : 2'd0;
         end
      end
   end

   // idle items produce nothing and are dropped here
   assign push              = accept && (unit_start || has_payload);
   assign push_desc.need_zb = unit_start && lead_zero_needed(codec_kind, unit_type, first_unit);
   assign push_desc.start   = unit_start;
   assign push_desc.esc     = esc;
   assign push_desc.has_pl  = has_payload;
   assign push_desc.data    = payload_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_count_ff <= 2'd0;
      end else if (accept) begin
         zero_count_ff <= zero_count_in;
      end
   end

endmodule

@@ rtl/abp_queue.sv @@
// Small FIFO of classified items between front and back.
module abp_queue
   import abp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  abp_desc_type push_desc,
   input  logic         pop,
   output abp_desc_type head_desc,
   output logic         full,
   output logic         empty
);

   abp_desc_type          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff;
   logic                  do_push;
   logic                  do_pop;

   assign full      = (count_ff == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_desc = entry_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (QUEUE_AW+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (QUEUE_AW+1)'(1);
         end
      end
   end

endmodule

@@ rtl/abp_back.sv @@
// Back end: expands each classified item into stream bytes, one per cycle unless the output stalls.
module abp_back
   import abp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  abp_desc_type head_desc,
   input  logic         queue_empty,
   output logic         pop,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [7:0]   out_byte,
   output logic         last_of_run
);

   abp_mask_type mask_ff;
   abp_mask_type mask_in;
   abp_mask_type head_mask;
   abp_mask_type lowest;
   abp_mask_type rest;
   logic [7:0]   data_ff;
   logic [7:0]   sel_byte;
   logic         rsp_valid_ff;
   logic [7:0]   rsp_byte_ff;
   logic         rsp_last_ff;
   logic         slot_free;
   logic         emit;

   // slots to emit for the item at the queue head
   always_comb begin
      head_mask           = '0;
      head_mask[POS_ZB]   = head_desc.need_zb;
      head_mask[POS_SC0]  = head_desc.start;
      head_mask[POS_SC1]  = head_desc.start;
      head_mask[POS_SC2]  = head_desc.start;
      head_mask[POS_EPB]  = head_desc.esc;
      head_mask[POS_DATA] = head_desc.has_pl;
   end

   assign lowest    = mask_ff & (~mask_ff + NUM_POS'(1));
   assign rest      = mask_ff & ~lowest;
   assign slot_free = !rsp_valid_ff || out_ready;
   assign emit      = slot_free && (mask_ff != '0);
   // fetch the next item when none is in hand or as the current one hands over its last byte
   assign pop       = !queue_empty && ((mask_ff == '0) || (emit && (rest == '0)));

   always_comb begin
      if (lowest[POS_SC2]) begin
         sel_byte = BYTE_SC_END;
      end else if (lowest[POS_EPB]) begin
         sel_byte = BYTE_EPB;
      end else if (lowest[POS_DATA]) begin
         sel_byte = data_ff;
      end else begin
         sel_byte = BYTE_ZERO;
      end
   end

   always_comb begin
      if (pop) begin
         mask_in = head_mask;
      end else if (emit) begin
         mask_in = rest;
      end else begin
         mask_in = mask_ff;
      end
   end

   // item in hand
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= head_desc.data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= sel_byte;
         rsp_last_ff <= (rest == '0);
      end
   end

   assign out_valid   = rsp_valid_ff;
   assign out_byte    = rsp_byte_ff;
   assign last_of_run = rsp_last_ff;

endmodule

@@ rtl/annexb_byte_stream_packer_top.sv @@
// Top level of the Annex B byte stream packer.
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+-----------------------------------------------
//  req_chan  | in  | valid / ready    | payload_byte, has_payload, unit_start,
//            |     |                  | first_unit, unit_type
//  rsp_chan  | out | valid / ready    | out_byte, last_of_run
//  csr_*     | in  | csr_write_enable | csr_write_data (codec_kind)
//
// One output byte leaves per cycle unless the output stalls; an item causes 1 to 5 bytes,
// which the back end emits one slot of its byte mask per cycle.
// Input transactions are taken every cycle while the 4-entry queue has room.
// When idle, a transaction's first byte passes the queue, item register and output register.
// Reset is synchronous: queue, zero run, codec_kind and output valid clear.
// Each side stalls on its own; the queue and output register absorb backpressure.
module annexb_byte_stream_packer_top
   import abp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   abp_req_if.sink    req_chan,
   abp_rsp_if.source  rsp_chan,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data
);

   logic [1:0]   codec_kind_ff;
   logic         queue_full;
   logic         queue_empty;
   logic         push;
   logic         pop;
   abp_desc_type push_desc;
   abp_desc_type head_desc;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         codec_kind_ff <= CODEC_H264;
      end else if (csr_write_enable) begin
         codec_kind_ff <= csr_write_data;
      end
   end

   abp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .codec_kind   (codec_kind_ff),
      .in_valid     (req_chan.valid),
      .in_ready     (req_chan.ready),
      .payload_byte (req_chan.payload_byte),
      .has_payload  (req_chan.has_payload),
      .unit_start   (req_chan.unit_start),
      .first_unit   (req_chan.first_unit),
      .unit_type    (req_chan.unit_type),
      .queue_full   (queue_full),
      .push         (push),
      .push_desc    (push_desc)
   );

   abp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   abp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_desc   (head_desc),
      .queue_empty (queue_empty),
      .pop         (pop),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_byte    (rsp_chan.out_byte),
      .last_of_run (rsp_chan.last_of_run)
   );

endmodule

@@ rtl/abp_checker.sv @@
// Port-level checks for the Annex B byte stream packer, bound to the top level.
module abp_checker
   import abp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       last_of_run
);

   // nothing left over from before reset
   a_reset_clears_out: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   // queue is empty after reset, so input is open
   a_reset_opens_in: assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready after reset");

   // a stalled transaction holds
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(last_of_run))
      else $error("stalled output changed");

   // only start code, zero byte or escape bytes come before an item's last byte
   a_inner_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last_of_run |->
         (out_byte == BYTE_ZERO || out_byte == BYTE_SC_END || out_byte == BYTE_EPB))
      else $error("unexpected non-final byte");

endmodule

bind annexb_byte_stream_packer_top abp_checker u_abp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .out_byte    (rsp_chan.out_byte),
   .last_of_run (rsp_chan.last_of_run)
);

@@ verif/abp_stream_checker.sv @@
// Stream checker: predicts the Annex B byte stream and compares every output transaction.
`timescale 1ns / 1ps

module abp_stream_checker
   import abp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // input channel, watched only
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_payload_byte,
   input  logic       req_has_payload,
   input  logic       req_unit_start,
   input  logic       req_first_unit,
   input  logic [5:0] req_unit_type,
   // result channel, watched only
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_last_of_run,
   // register write port
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data,
   output int         mismatch_count,
   output int         bytes_owed
);

   typedef struct {
      logic [7:0] value;
      logic       last;
   } stream_byte_type;

   stream_byte_type owed_bytes[$];
   logic [1:0]      codec_sel  = CODEC_H264;
   logic [1:0]      zeros_seen = 2'd0;
   int              fails      = 0;
   int              owed_total = 0;

   assign mismatch_count = fails;
   assign bytes_owed     = owed_total;

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fails++;
   endtask

   // leading zero wanted for this unit?
   function automatic logic lead_zero_wanted(input logic [1:0] kind,
                                             input logic [5:0] utype,
                                             input logic       first);
      if (first)
         return 1'b1;
      case (kind)
         CODEC_H264: return utype == 6'd7 || utype == 6'd8;
         CODEC_HEVC: return utype >= 6'd32 && utype <= 6'd34;
         CODEC_VVC:  return utype >= 6'd12 && utype <= 6'd18;
         default:    return 1'b0;
      endcase
   endfunction

   // bytes one input transaction puts on the stream, queued in order
   function automatic void predict_annexb_bytes(input logic [7:0] data,
                                                input logic       has,
                                                input logic       start,
                                                input logic       first,
                                                input logic [5:0] utype);
      logic [7:0]      run[$];
      stream_byte_type sb;
      if (start) begin
         zeros_seen = 2'd0;
         if (lead_zero_wanted(codec_sel, utype, first))
            run.push_back(BYTE_ZERO);
         run.push_back(BYTE_ZERO);
         run.push_back(BYTE_ZERO);
         run.push_back(BYTE_SC_END);
      end
      if (has) begin
         // two zeros seen: a byte of 3 or less gets an escape byte first
         if (zeros_seen == 2'd2) begin
            if (data[7:2] == 6'd0)
               run.push_back(BYTE_EPB);
            zeros_seen = (data == BYTE_ZERO) ? 2'd1 : 2'd0;
         end else begin
            zeros_seen = (data == BYTE_ZERO) ? zeros_seen + 2'd1 : 2'd0;
         end
         run.push_back(data);
      end
      foreach (run[i]) begin
         sb.value = run[i];
         sb.last  = (i == run.size() - 1);
         owed_bytes.push_back(sb);
      end
   endfunction

   // watch both channels at each rising edge
   always @(posedge clock) begin
      stream_byte_type want;
      if (reset) begin
         codec_sel  = CODEC_H264;
         zeros_seen = 2'd0;
         owed_bytes.delete();
      end else begin
         if (csr_write_enable)
            codec_sel = csr_write_data;
         if (req_valid && req_ready)
            predict_annexb_bytes(req_payload_byte, req_has_payload, req_unit_start,
                                 req_first_unit, req_unit_type);
         if (rsp_valid && rsp_ready) begin
            if (owed_bytes.size() == 0) begin
               report_mismatch($sformatf("byte %02h last %b with nothing expected",
                                         rsp_out_byte, rsp_last_of_run));
            end else begin
               want = owed_bytes.pop_front();
               if (rsp_out_byte !== want.value)
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_out_byte, want.value));
               if (rsp_last_of_run !== want.last)
                  report_mismatch($sformatf("last_of_run %b, expected %b (byte %02h)",
                                            rsp_last_of_run, want.last, want.value));
            end
         end
      end
      owed_total = owed_bytes.size();
   end

endmodule

@@ verif/annexb_byte_stream_packer_top_tb.sv @@
// Testbench top: drives NAL unit transactions and register writes, gives the verdict.
`timescale 1ns / 1ps

module annexb_byte_stream_packer_top_tb
   import abp_pkg::*;
();

   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 12;
   localparam int NUM_PHASES   = 5;

   localparam logic [1:0] PHASE_CODEC [NUM_PHASES] =
      '{CODEC_OTHER, CODEC_HEVC, CODEC_VVC, CODEC_H264, CODEC_VVC};
   localparam int PHASE_GAP   [NUM_PHASES] = '{25, 0, 40, 10, 0};
   localparam int PHASE_STALL [NUM_PHASES] = '{25, 0, 15, 40, 0};
   // unit types on either side of every codec's leading-zero type ranges
   localparam logic [5:0] BOUNDARY_TYPES [14] =
      '{6'd0, 6'd6, 6'd7, 6'd8, 6'd9, 6'd11, 6'd12, 6'd18, 6'd19, 6'd31, 6'd32,
        6'd34, 6'd35, 6'd63};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [1:0] csr_write_data   = 2'd0;
   int         req_gap_pct   = 0;
   int         rsp_stall_pct = 0;
   int         idle_cycles   = 0;
   int         mismatch_count;
   int         bytes_owed;

   abp_req_if req_chan ();
   abp_rsp_if rsp_chan ();

   always #4 clock = ~clock;

   annexb_byte_stream_packer_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   abp_stream_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_payload_byte (req_chan.payload_byte),
      .req_has_payload  (req_chan.has_payload),
      .req_unit_start   (req_chan.unit_start),
      .req_first_unit   (req_chan.first_unit),
      .req_unit_type    (req_chan.unit_type),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_out_byte     (rsp_chan.out_byte),
      .rsp_last_of_run  (rsp_chan.last_of_run),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .bytes_owed       (bytes_owed)
   );

   // watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("annexb_byte_stream_packer_top_tb: FAIL");
         $finish;
      end
   end

   // output side: stall bursts on ready, started at random at rsp_stall_pct percent
   initial begin
      int stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
            rsp_chan.ready = 1'b0;
            stall_left     = $urandom_range(1, 8) - 1;
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   // present one transaction, optionally after a gap, and wait until it is taken
   task automatic offer_nal_item(input logic [7:0] data, input logic has,
                                 input logic start, input logic first,
                                 input logic [5:0] utype);
      int gap;
      if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_chan.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid        = 1'b1;
      req_chan.payload_byte = data;
      req_chan.has_payload  = has;
      req_chan.unit_start   = start;
      req_chan.first_unit   = first;
      req_chan.unit_type    = utype;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // zero-heavy payload so that escape cases come up often
   function automatic logic [7:0] pick_payload();
      case ($urandom_range(9))
         0, 1, 2, 3: return BYTE_ZERO;
         4, 5, 6:    return 8'($urandom_range(1, 3));
         7:          return 8'd4;
         default:    return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [5:0] pick_type();
      if ($urandom_range(1) == 0)
         return BOUNDARY_TYPES[$urandom_range(13)];
      return 6'($urandom_range(63));
   endfunction

   // register write once everything owed has left and the queue has settled
   task automatic program_codec(input logic [1:0] kind);
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (bytes_owed != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = kind;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // mostly well-formed units with random content, some noise transactions
   task automatic send_nal_units(input int quota);
      int         sent;
      int         body;
      logic [7:0] data;
      logic [5:0] utype;
      logic       has;
      logic       start;
      logic       first;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(9) == 0) begin
            data  = 8'($urandom);
            has   = 1'($urandom);
            start = 1'($urandom);
            first = 1'($urandom);
            utype = 6'($urandom);
            offer_nal_item(data, has, start, first, utype);
            if (has || start)
               sent++;
         end else begin
            offer_nal_item(pick_payload(), $urandom_range(7) != 0, 1'b1,
                           $urandom_range(2) == 0, pick_type());
            sent++;
            body = $urandom_range(0, 8);
            repeat (body) begin
               if ($urandom_range(11) == 0) begin
                  offer_nal_item(pick_payload(), 1'b0, 1'b0, 1'($urandom), 6'($urandom));
               end else begin
                  offer_nal_item(pick_payload(), 1'b1, 1'b0, 1'($urandom), 6'($urandom));
                  sent++;
               end
            end
         end
      end
   endtask

   // stimulus
   initial begin
      req_chan.valid        = 1'b0;
      req_chan.payload_byte = 8'd0;
      req_chan.has_payload  = 1'b0;
      req_chan.unit_start   = 1'b0;
      req_chan.first_unit   = 1'b0;
      req_chan.unit_type    = 6'd0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      program_codec(CODEC_H264);
      req_gap_pct   = 20;
      rsp_stall_pct = 20;

      // payload before any unit start runs on the reset zero count
      offer_nal_item(8'h00, 1'b1, 1'b0, 1'b0, 6'd0);
      offer_nal_item(8'h00, 1'b1, 1'b0, 1'b0, 6'd0);
      offer_nal_item(8'h02, 1'b1, 1'b0, 1'b0, 6'd0);
      // first unit of the access unit, escapes of 00 and 03, no escape of 04
      offer_nal_item(8'h00, 1'b1, 1'b1, 1'b1, 6'd1);
      offer_nal_item(8'h00, 1'b1, 1'b0, 1'b0, 6'd0);
      offer_nal_item(8'h00, 1'b1, 1'b0, 1'b0, 6'd0);
      offer_nal_item(8'h00, 1'b1, 1'b0, 1'b0, 6'd0);
      offer_nal_item(8'h03, 1'b1, 1'b0, 1'b0, 6'd0);
      offer_nal_item(8'h00, 1'b1, 1'b0, 1'b0, 6'd0);
      offer_nal_item(8'h00, 1'b1, 1'b0, 1'b0, 6'd0);
      offer_nal_item(8'h04, 1'b1, 1'b0, 1'b0, 6'd0);
      // leading-zero types, an empty unit start, a type without one
      offer_nal_item(8'hFF, 1'b1, 1'b1, 1'b0, 6'd7);
      offer_nal_item(8'h00, 1'b0, 1'b1, 1'b0, 6'd8);
      offer_nal_item(8'h00, 1'b1, 1'b1, 1'b0, 6'd6);
      offer_nal_item(8'h00, 1'b1, 1'b0, 1'b0, 6'd0);
      // idle transaction leaves the zero run alone
      offer_nal_item(8'hAA, 1'b0, 1'b0, 1'b1, 6'd63);
      offer_nal_item(8'h01, 1'b1, 1'b0, 1'b0, 6'd0);
      offer_nal_item(8'h00, 1'b0, 1'b1, 1'b0, 6'd9);
      offer_nal_item(8'h80, 1'b1, 1'b1, 1'b1, 6'd63);
      // unit start clears a pending zero run
      offer_nal_item(8'h00, 1'b1, 1'b0, 1'b0, 6'd0);
      offer_nal_item(8'h00, 1'b1, 1'b0, 1'b0, 6'd0);
      offer_nal_item(8'h02, 1'b1, 1'b1, 1'b0, 6'd0);
      offer_nal_item(8'hFF, 1'b1, 1'b0, 1'b0, 6'd0);

      // random phases, one codec each; the last one runs without idling
      for (int p = 0; p < NUM_PHASES; p++) begin
         program_codec(PHASE_CODEC[p]);
         req_gap_pct   = PHASE_GAP[p];
         rsp_stall_pct = PHASE_STALL[p];
         send_nal_units(61);
      end

      @(negedge clock);
      req_chan.valid = 1'b0;
      while (bytes_owed != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("annexb_byte_stream_packer_top_tb: PASS");
      else
         $display("annexb_byte_stream_packer_top_tb: FAIL");
      $finish;
   end

endmodule
